FILE: sv/fmw_pkg.sv
package fmw_pkg;

  // walker mode
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_DATA   = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_TYPE = 3'd1,
    STAT_HDR_SUM  = 3'd2,
    STAT_ZERO_LEN = 3'd3,
    STAT_REC_SUM  = 3'd4
  } status_t;

  // register indexes
  localparam logic REG_FMC_TYPE = 1'b0;
  localparam logic REG_OUI      = 1'b1;

  localparam logic [7:0]  TYPE_BAD_LOW  = 8'h06;
  localparam logic [7:0]  TYPE_BAD_HIGH = 8'hBF;
  localparam int          EOL_BIT       = 7;
  localparam logic [7:0]  FMC_RESET     = 8'hFA;
  localparam logic [23:0] OUI_RESET     = 24'h0012A2;
  localparam logic [7:0]  COUNT_MAX     = 8'hFF;

  // header bytes before data; data byte d sits at position DATA_BASE + d
  localparam logic [8:0]  DATA_BASE     = 9'd5;

  typedef struct packed {
    status_t    status;
    logic [7:0] record_type;
    logic [7:0] record_length;
    logic       end_of_list;
    logic [7:0] record_index;
    logic       is_fmc;
    logic       oui_match;
    logic [3:0] fmc_subtype;
  } res_t;

endpackage

FILE: sv/fmw_core.sv
module fmw_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          area_start,
  input  logic [7:0]    fmc_type_id,
  input  logic [23:0]   expected_oui,
  output logic          res_emit,
  output fmw_pkg::res_t res
);

  fmw_pkg::mode_t mode_r, mode_nxt, mode_v;
  logic [8:0]  pos_r, pos_nxt, pos_v;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  rsum_r, rsum_nxt;
  logic        eol_r, eol_nxt;
  logic [23:0] oui_r, oui_nxt;
  logic [3:0]  sub_r, sub_nxt;
  logic [7:0]  cnt_r, cnt_nxt, cnt_v;

  logic [7:0]  sum_add;
  logic [8:0]  d;
  logic        last;
  logic        ok;
  fmw_pkg::status_t stat;

  always_comb begin
    mode_v   = area_start ? fmw_pkg::MODE_HEADER : mode_r;
    pos_v    = area_start ? 9'd0 : pos_r;
    cnt_v    = area_start ? 8'd0 : cnt_r;

    mode_nxt = mode_v;
    pos_nxt  = pos_v;
    cnt_nxt  = cnt_v;
    sum_nxt  = sum_r;
    type_nxt = type_r;
    len_nxt  = len_r;
    rsum_nxt = rsum_r;
    eol_nxt  = eol_r;
    oui_nxt  = oui_r;
    sub_nxt  = sub_r;
    res_emit = 1'b0;
    stat     = fmw_pkg::STAT_OK;

    sum_add  = sum_r + data_byte;
    d        = pos_v - fmw_pkg::DATA_BASE;
    last     = ({1'b0, d} + 10'd1) >= {2'b00, len_r};

    case (mode_v)
      fmw_pkg::MODE_HEADER: begin
        case (pos_v)
          9'd0: begin
            type_nxt = data_byte;
            len_nxt  = 8'd0;
            rsum_nxt = 8'd0;
            eol_nxt  = 1'b0;
            oui_nxt  = 24'd0;
            sub_nxt  = 4'd0;
            sum_nxt  = data_byte;
            pos_nxt  = 9'd1;
            if (data_byte >= fmw_pkg::TYPE_BAD_LOW &&
                data_byte <= fmw_pkg::TYPE_BAD_HIGH) begin
              mode_nxt = fmw_pkg::MODE_IDLE;
              res_emit = 1'b1;
              stat     = fmw_pkg::STAT_BAD_TYPE;
            end
          end
          9'd1: begin
            eol_nxt = data_byte[fmw_pkg::EOL_BIT];
            sum_nxt = sum_add;
            pos_nxt = pos_v + 9'd1;
          end
          9'd2: begin
            len_nxt = data_byte;
            sum_nxt = sum_add;
            pos_nxt = pos_v + 9'd1;
          end
          9'd3: begin
            rsum_nxt = data_byte;
            sum_nxt  = sum_add;
            pos_nxt  = pos_v + 9'd1;
          end
          default: begin
            // header checksum byte
            sum_nxt = sum_add;
            if (sum_add != 8'd0) begin
              mode_nxt = fmw_pkg::MODE_IDLE;
              res_emit = 1'b1;
              stat     = fmw_pkg::STAT_HDR_SUM;
            end else if (len_r == 8'd0) begin
              mode_nxt = fmw_pkg::MODE_IDLE;
              res_emit = 1'b1;
              stat     = fmw_pkg::STAT_ZERO_LEN;
            end else begin
              sum_nxt  = 8'd0;
              pos_nxt  = fmw_pkg::DATA_BASE;
              mode_nxt = fmw_pkg::MODE_DATA;
            end
          end
        endcase
      end
      fmw_pkg::MODE_DATA: begin
        sum_nxt = sum_add;
        if (d < 9'd3) begin
          case (d[1:0])
            2'd0:    oui_nxt[7:0]   = oui_r[7:0]   | data_byte;
            2'd1:    oui_nxt[15:8]  = oui_r[15:8]  | data_byte;
            default: oui_nxt[23:16] = oui_r[23:16] | data_byte;
          endcase
        end else if (d == 9'd3) begin
          sub_nxt = data_byte[7:4];
        end
        if (last) begin
          res_emit = 1'b1;
          if (sum_add + rsum_r != 8'd0) begin
            mode_nxt = fmw_pkg::MODE_IDLE;
            stat     = fmw_pkg::STAT_REC_SUM;
          end else if (eol_r) begin
            mode_nxt = fmw_pkg::MODE_IDLE;
          end else begin
            if (cnt_v != fmw_pkg::COUNT_MAX) cnt_nxt = cnt_v + 8'd1;
            mode_nxt = fmw_pkg::MODE_HEADER;
            pos_nxt  = 9'd0;
          end
        end else begin
          pos_nxt = pos_v + 9'd1;
        end
      end
      default: begin
        mode_nxt = fmw_pkg::MODE_IDLE;
      end
    endcase

    // result fields come from the updated record state
    ok                = (stat == fmw_pkg::STAT_OK);
    res.status        = stat;
    res.record_type   = type_nxt;
    res.record_length = len_nxt;
    res.end_of_list   = eol_nxt;
    res.record_index  = cnt_v;
    res.is_fmc        = (type_nxt == fmc_type_id);
    res.oui_match     = ok && res.is_fmc && (len_nxt >= 8'd3) &&
                        (oui_nxt == expected_oui);
    res.fmc_subtype   = (ok && res.is_fmc && (len_nxt >= 8'd4)) ? sub_nxt : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fmw_pkg::MODE_IDLE;
      pos_r  <= 9'd0;
      sum_r  <= 8'd0;
      type_r <= 8'd0;
      len_r  <= 8'd0;
      rsum_r <= 8'd0;
      eol_r  <= 1'b0;
      oui_r  <= 24'd0;
      sub_r  <= 4'd0;
      cnt_r  <= 8'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      rsum_r <= rsum_nxt;
      eol_r  <= eol_nxt;
      oui_r  <= oui_nxt;
      sub_r  <= sub_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: sv/fru_multirecord_walker.sv
// Channel | Signals                                   | Item
// --------+-------------------------------------------+-------------------------------
// in      | in_valid/in_ready, in_data_byte,          | one byte of the MultiRecord area
//         | in_area_start                             |
// out     | out_valid/out_ready, out_status, ...      | one record result
// cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | 0x0 fmc_type_id, 0x4 expected_oui
//
// One byte per cycle while in_ready is high; a result is registered into the output
// register (or the skid) as the byte that ends its record (or its first error) is taken.
// Reset (rst_n low, synchronous) returns the walker to idle and loads the
// register reset values; no clearing pass.
// Stalls: results sit in the output register plus a one-entry skid; bytes keep
// flowing until the skid fills, then in_ready drops until out_ready frees a slot.
module fru_multirecord_walker (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_area_start,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_record_length,
  output logic        out_end_of_list,
  output logic [7:0]  out_record_index,
  output logic        out_is_fmc,
  output logic        out_oui_match,
  output logic [3:0]  out_fmc_subtype,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [7:0]  fmc_type_r;
  logic [23:0] oui_r;
  logic        cfg_wr;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];     // register index; byte offset bits ignored
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmc_type_r <= fmw_pkg::FMC_RESET;
      oui_r      <= fmw_pkg::OUI_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == fmw_pkg::REG_FMC_TYPE) fmc_type_r <= pwdata[7:0];
      else                                  oui_r      <= pwdata[23:0];
    end
  end

  always_comb begin
    if (reg_sel == fmw_pkg::REG_OUI) prdata = {8'd0, oui_r};
    else                             prdata = {24'd0, fmc_type_r};
  end

  // walker
  logic          accept;
  logic          res_emit;
  fmw_pkg::res_t res;

  // output register + skid
  logic          out_valid_r;
  logic          skid_valid_r;
  fmw_pkg::res_t out_r;
  fmw_pkg::res_t skid_r;
  logic          push;
  logic          pop;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  fmw_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .area_start   (in_area_start),
    .fmc_type_id  (fmc_type_r),
    .expected_oui (oui_r),
    .res_emit     (res_emit),
    .res          (res)
  );

  assign push = accept && res_emit;
  assign pop  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no push possible while the skid is full
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) skid_valid_r <= 1'b1;
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (push) begin
      if (!out_valid_r || pop) out_r  <= res;
      else                     skid_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_record_type   = out_r.record_type;
  assign out_record_length = out_r.record_length;
  assign out_end_of_list   = out_r.end_of_list;
  assign out_record_index  = out_r.record_index;
  assign out_is_fmc        = out_r.is_fmc;
  assign out_oui_match     = out_r.oui_match;
  assign out_fmc_subtype   = out_r.fmc_subtype;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_oui_only_ok_fmc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_oui_match |-> out_is_fmc && out_status == fmw_pkg::STAT_OK)
    else $error("oui_match on a non-FMC or failed record");

  a_subtype_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fmc_subtype != 4'd0 |->
      out_is_fmc && out_record_length >= 8'd4 && out_status == fmw_pkg::STAT_OK)
    else $error("subtype reported for a record that cannot carry one");

  a_bad_type_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fmw_pkg::STAT_BAD_TYPE |->
      out_record_length == 8'd0 && !out_end_of_list)
    else $error("invalid-type result carries header fields");

endmodule

FILE: bench/fru_multirecord_walker_tb.sv
module fru_multirecord_walker_tb;

  // clock period 8, run guard far above the slowest legal run
  localparam int CYCLE_LIMIT   = 400000;
  // cycles to let the walker settle after the last expected result
  localparam int SETTLE_CYCLES = 6;
  // long receiver stall used to fill the output skid
  localparam int HOLD_CYCLES   = 80;
  localparam int MAX_PRINTS    = 60;

  // how a generated record is damaged
  typedef enum {
    FAULT_NONE,
    FAULT_HDR_SUM,
    FAULT_REC_SUM,
    FAULT_CUT
  } rec_fault_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_area_start = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_record_type;
  logic [7:0]  out_record_length;
  logic        out_end_of_list;
  logic [7:0]  out_record_index;
  logic        out_is_fmc;
  logic        out_oui_match;
  logic [3:0]  out_fmc_subtype;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  always #4 clk = ~clk;

  fru_multirecord_walker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_area_start    (in_area_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_record_type  (out_record_type),
    .out_record_length(out_record_length),
    .out_end_of_list  (out_end_of_list),
    .out_record_index (out_record_index),
    .out_is_fmc       (out_is_fmc),
    .out_oui_match    (out_oui_match),
    .out_fmc_subtype  (out_fmc_subtype),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------------
  // Walker shadow: register copies and the per-record state the block keeps.
  // Updated once per accepted byte, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_fmc_type;
  logic [23:0] cfg_oui;

  fmw_pkg::mode_t walk_state;
  logic [8:0]  byte_pos;
  logic [7:0]  run_sum;      // header sum, then data sum
  logic [7:0]  cur_type;
  logic [7:0]  cur_len;
  logic [7:0]  cur_rec_sum;
  logic        cur_eol;
  logic [23:0] oui_acc;
  logic [3:0]  sub_hold;
  logic [7:0]  rec_count;

  fmw_pkg::res_t expected_records[$];

  int error_count = 0;
  int item_count = 0;
  int cycle_count = 0;

  // idling odds in percent, changed only at a rising edge
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  // receiver hold-off: the test bumps the token, the receiver owns the count
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  task automatic shadow_reset();
    cfg_fmc_type = fmw_pkg::FMC_RESET;
    cfg_oui      = fmw_pkg::OUI_RESET;
    walk_state   = fmw_pkg::MODE_IDLE;
    byte_pos     = '0;
    run_sum      = '0;
    cur_type     = '0;
    cur_len      = '0;
    cur_rec_sum  = '0;
    cur_eol      = 1'b0;
    oui_acc      = '0;
    sub_hold     = '0;
    rec_count    = '0;
  endtask

  // Result for the current record. Only a good record reports OUI and subtype,
  // and only when the data was long enough to carry them.
  function automatic fmw_pkg::res_t record_result(fmw_pkg::status_t st);
    fmw_pkg::res_t r;
    r.status        = st;
    r.record_type   = cur_type;
    r.record_length = cur_len;
    r.end_of_list   = cur_eol;
    r.record_index  = rec_count;
    r.is_fmc        = (cur_type == cfg_fmc_type);
    r.oui_match     = (st == fmw_pkg::STAT_OK) && r.is_fmc && (cur_len >= 8'd3) &&
                      (oui_acc == cfg_oui);
    r.fmc_subtype   = (st == fmw_pkg::STAT_OK && r.is_fmc && cur_len >= 8'd4) ?
                      sub_hold : 4'd0;
    return r;
  endfunction

  task automatic walk_predict(input logic [7:0] b, input logic start);
    logic [8:0] off;
    if (start) begin
      // a start always restarts, even mid-record
      walk_state = fmw_pkg::MODE_HEADER;
      byte_pos   = '0;
      rec_count  = '0;
    end else if (walk_state != fmw_pkg::MODE_HEADER &&
                 walk_state != fmw_pkg::MODE_DATA) begin
      walk_state = fmw_pkg::MODE_IDLE;
      return;
    end

    if (walk_state == fmw_pkg::MODE_HEADER) begin
      case (byte_pos)
        9'd0: begin
          cur_type    = b;
          cur_len     = '0;
          cur_rec_sum = '0;
          cur_eol     = 1'b0;
          oui_acc     = '0;
          sub_hold    = '0;
          run_sum     = b;
          byte_pos    = 9'd1;
          // reserved type range fails on the type byte itself
          if (b >= fmw_pkg::TYPE_BAD_LOW && b <= fmw_pkg::TYPE_BAD_HIGH) begin
            walk_state = fmw_pkg::MODE_IDLE;
            expected_records.push_back(record_result(fmw_pkg::STAT_BAD_TYPE));
          end
          return;
        end
        9'd1: cur_eol = b[fmw_pkg::EOL_BIT];
        9'd2: cur_len = b;
        9'd3: cur_rec_sum = b;
        default: begin
          run_sum = run_sum + b;
          if (run_sum != 8'd0) begin
            walk_state = fmw_pkg::MODE_IDLE;
            expected_records.push_back(record_result(fmw_pkg::STAT_HDR_SUM));
          end else if (cur_len == 8'd0) begin
            walk_state = fmw_pkg::MODE_IDLE;
            expected_records.push_back(record_result(fmw_pkg::STAT_ZERO_LEN));
          end else begin
            run_sum    = '0;
            byte_pos   = fmw_pkg::DATA_BASE;
            walk_state = fmw_pkg::MODE_DATA;
          end
          return;
        end
      endcase
      run_sum  = run_sum + b;
      byte_pos = byte_pos + 9'd1;
      return;
    end

    // data bytes: OUI little-endian in 0..2, subtype in the top of byte 3
    off     = byte_pos - fmw_pkg::DATA_BASE;
    run_sum = run_sum + b;
    if (off < 9'd3)
      oui_acc = oui_acc | (24'(b) << (8 * off));
    else if (off == 9'd3)
      sub_hold = b[7:4];

    if (int'(off) + 1 >= int'(cur_len)) begin
      if (8'(run_sum + cur_rec_sum) != 8'd0) begin
        walk_state = fmw_pkg::MODE_IDLE;
        expected_records.push_back(record_result(fmw_pkg::STAT_REC_SUM));
      end else begin
        expected_records.push_back(record_result(fmw_pkg::STAT_OK));
        if (cur_eol) begin
          walk_state = fmw_pkg::MODE_IDLE;
        end else begin
          if (rec_count != fmw_pkg::COUNT_MAX)
            rec_count = rec_count + 8'd1;
          walk_state = fmw_pkg::MODE_HEADER;
          byte_pos   = '0;
        end
      end
    end else begin
      byte_pos = byte_pos + 9'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS)
      $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    fmw_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        report_error("result with no record pending");
      end else begin
        want = expected_records.pop_front();
        check_field("status", out_status, want.status);
        check_field("record_type", out_record_type, want.record_type);
        check_field("record_length", out_record_length, want.record_length);
        check_field("end_of_list", out_end_of_list, want.end_of_list);
        check_field("record_index", out_record_index, want.record_index);
        check_field("is_fmc", out_is_fmc, want.is_fmc);
        check_field("oui_match", out_oui_match, want.oui_match);
        check_field("fmc_subtype", out_fmc_subtype, want.fmc_subtype);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when the test asks for one.
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fru_multirecord_walker_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers; all of them start and end at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one byte, holding it until taken. Valid is left high on return so
  // back-to-back items need no bubble; the caller lowers it when done.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_area_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    walk_predict(b, start);
    item_count++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every pending result, then let the walker settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == fmw_pkg::REG_FMC_TYPE)
      cfg_fmc_type = value[7:0];
    else
      cfg_oui = value[23:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    @(posedge clk);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    @(negedge clk);
  endtask

  // Build one record with consistent checksums, then damage it as asked.
  // A cut record stops short of its last byte; the next area must restart.
  task automatic send_record(input bit first, input logic [7:0] rtype, input bit eol,
                             input int len, input rec_fault_t fault, input bit oui_ok);
    logic [7:0] hdr[5];
    logic [7:0] body[$];
    logic [7:0] b;
    logic [7:0] dsum;
    int total;
    dsum = '0;
    for (int i = 0; i < len; i++) begin
      if (rtype == cfg_fmc_type && oui_ok && i < 3)
        b = cfg_oui[8*i +: 8];
      else
        b = 8'($urandom);
      body.push_back(b);
      dsum = dsum + b;
    end
    hdr[0] = rtype;
    hdr[1] = {eol, 7'($urandom)};
    hdr[2] = 8'(len);
    hdr[3] = 8'(0) - dsum;
    if (fault == FAULT_REC_SUM)
      hdr[3] = hdr[3] ^ 8'($urandom_range(1, 255));
    hdr[4] = 8'(0) - 8'(hdr[0] + hdr[1] + hdr[2] + hdr[3]);
    if (fault == FAULT_HDR_SUM)
      hdr[4] = hdr[4] ^ 8'($urandom_range(1, 255));

    total = 5 + len;
    if (fault == FAULT_CUT)
      total = $urandom_range(1, 4 + len);
    for (int k = 0; k < total; k++)
      send_byte((k < 5) ? hdr[k] : body[k-5], first && k == 0);
  endtask

  task automatic write_config(input logic [7:0] fmc_type, input logic [23:0] oui);
    wait_idle();
    apply_regs: begin
      apb_write(fmw_pkg::REG_FMC_TYPE, {24'($urandom), fmc_type});
      apb_write(fmw_pkg::REG_OUI, {8'($urandom), oui});
    end
  endtask

  function automatic logic [7:0] legal_type();
    int v;
    v = $urandom_range(0, 69);
    return (v < 6) ? 8'(v) : 8'(8'hC0 + v - 6);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stray byte after reset: walker is idle, nothing comes out.
  task automatic test_idle_bytes();
    send_byte(8'hFF, 1'b0);
  endtask

  // Both edges of the reserved type range, each on a fresh area start.
  task automatic test_bad_types();
    send_byte(fmw_pkg::TYPE_BAD_LOW, 1'b1);
    send_byte(fmw_pkg::TYPE_BAD_HIGH, 1'b1);
  endtask

  task automatic test_header_faults();
    send_record(1'b1, 8'h00, 1'b0, 2, FAULT_HDR_SUM, 1'b0);
    // zero length with a good header sum
    send_record(1'b1, 8'hFF, 1'b0, 0, FAULT_NONE, 1'b0);
  endtask

  // A start in the middle of a record drops it without a result.
  task automatic test_restart_mid_record();
    send_record(1'b1, 8'h01, 1'b0, 1, FAULT_CUT, 1'b0);
  endtask

  // Good FMC record with the reset OUI, then a record with a bad data sum
  // at index 1.
  task automatic test_fmc_record();
    send_record(1'b1, fmw_pkg::FMC_RESET, 1'b0, 4, FAULT_NONE, 1'b1);
    send_record(1'b0, 8'hC0, 1'b1, 1, FAULT_REC_SUM, 1'b0);
  endtask

  // Mostly well-formed areas with random content; some faults, cut records,
  // stray bytes and pauses until the walker has drained.
  task automatic test_random_areas(input int n_items);
    int start_count;
    int nrec;
    int p;
    int len;
    logic [7:0] rtype;
    rec_fault_t fault;
    bit eol;
    start_count = item_count;
    while (item_count - start_count < n_items) begin
      nrec = $urandom_range(1, 6);
      for (int r = 0; r < nrec; r++) begin
        p = $urandom_range(99);
        if (p < 45)
          rtype = cfg_fmc_type;
        else if (p < 85)
          rtype = legal_type();
        else
          rtype = 8'($urandom);

        p = $urandom_range(99);
        if (p < 4)
          len = 0;
        else if (p < 5)
          len = $urandom_range(0, 1) ? 255 : $urandom_range(9, 254);
        else
          len = $urandom_range(1, 8);

        p = $urandom_range(99);
        if (p < 6)
          fault = FAULT_HDR_SUM;
        else if (p < 12)
          fault = FAULT_REC_SUM;
        else if (p < 17)
          fault = FAULT_CUT;
        else
          fault = FAULT_NONE;

        eol = (r == nrec - 1) || ($urandom_range(99) < 5);
        send_record(r == 0, rtype, eol, len, fault, $urandom_range(99) < 75);
        if (fault != FAULT_NONE || eol || len == 0 ||
            (rtype >= fmw_pkg::TYPE_BAD_LOW && rtype <= fmw_pkg::TYPE_BAD_HIGH))
          break;
      end
      // trailing noise the walker should ignore (or eat, after a cut)
      if ($urandom_range(99) < 25)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      // sender pause until every result is back
      if ($urandom_range(99) < 8)
        wait_idle();
    end
  endtask

  // Receiver stops for a long stretch while short records keep coming, so
  // the output register and skid fill and the input stalls.
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_token++;
    @(negedge clk);
    for (int r = 0; r < 10; r++)
      send_record(r == 0, legal_type(), r == 9, 1, FAULT_NONE, 1'b1);
    wait_idle();
  endtask

  // More than 256 records in one area: the index must stick at its maximum.
  // The FMC type is mixed in only when it is outside the reserved range.
  task automatic test_index_saturation();
    bit fmc_legal;
    fmc_legal = !(cfg_fmc_type >= fmw_pkg::TYPE_BAD_LOW &&
                  cfg_fmc_type <= fmw_pkg::TYPE_BAD_HIGH);
    for (int r = 0; r < 257; r++)
      send_record(r == 0,
                  (fmc_legal && $urandom_range(3) == 0) ? cfg_fmc_type : legal_type(),
                  r == 256, 1, FAULT_NONE, 1'b1);
    wait_idle();
  endtask

  initial begin
    shadow_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: slow sender, slower receiver, reset register values
    set_idling(37, 68);
    test_idle_bytes();
    test_bad_types();
    test_header_faults();
    test_restart_mid_record();
    test_fmc_record();

    write_config(8'h00, 24'hFFFFFF);
    test_random_areas(30);

    // phase 2: roles swapped, other register extremes
    wait_idle();
    set_idling(68, 37);
    write_config(8'hFF, 24'h000000);
    test_random_areas(30);

    // phase 3: no idling, random registers
    wait_idle();
    set_idling(0, 0);
    write_config(8'($urandom), 24'($urandom));
    test_output_backpressure();
    test_random_areas(30);
    test_index_saturation();

    wait_idle();
    if (error_count == 0)
      $display("fru_multirecord_walker_tb: done, clean");
    else
      $display("fru_multirecord_walker_tb: done, errors");
    $finish;
  end

endmodule
